>>> rtl/core/access_code_table_defines.svh
// Assertion macros shared by the access code table checkers.
// No dependencies; expects clk and rst to be visible where a macro is used.
`ifndef ACCESS_CODE_TABLE_DEFINES_SVH
`define ACCESS_CODE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ACT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ACT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/act_pkg.sv
// Shared types, widths and codes of the access code table.
// No dependencies; used by the top level and by its checker.
package act_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int VALUE_CHARS_DEF = 16;

  localparam int FUNC_W   = 2;
  localparam int TYPE_W   = 8;
  localparam int WORD_W   = 64;
  localparam int KB_W     = 2;
  localparam int RELAY_W  = 2;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 6;

  // Characters held in the two value words, one byte each.
  localparam int VALUE_BYTES = 2 * WORD_W / 8;
  localparam int VALUE_W     = 2 * WORD_W;

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL         = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_KEYBOARD = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_RELAY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE    = 3'd5;

  localparam logic [KB_W-1:0]    KB_ANY    = 2'd0;
  localparam logic [KB_W-1:0]    KB_MAX    = 2'd2;
  localparam logic [RELAY_W-1:0] RELAY_ONE = 2'd1;
  localparam logic [RELAY_W-1:0] RELAY_TWO = 2'd2;
  localparam logic [RELAY_W-1:0] RELAY_NONE = 2'd0;

  // One table row as stored in the entry memory.
  typedef struct packed {
    logic [TYPE_W-1:0]  type_code;
    logic [VALUE_W-1:0] value;
    logic [KB_W-1:0]    keyboard;
    logic [RELAY_W-1:0] relay;
  } entry_t;

endpackage

>>> rtl/core/access_code_table.sv
// Access code table: lookup, add and clear over a table of credentials.
// A clear, the unused func and a rejected add go straight to the done state; a lookup or a
// clean add scans rows 0 .. count-1 in order, one entry memory row per cycle, and stops at
// the first hit. The result is registered in the done state once the output register is free.
// Items: one at a time; the next item is taken once the result is registered,
// even while that result still waits for out_ready.
// Reset (rst, synchronous): empties the table, clears legacy_format and out_valid, returns to idle.
module access_code_table #(
  parameter int TABLE_DEPTH = act_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_CHARS = act_pkg::VALUE_CHARS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration write channel (legacy_format).
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data,
  // Input item channel.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [act_pkg::FUNC_W-1:0]   func,
  input  logic [act_pkg::TYPE_W-1:0]   type_code,
  input  logic [act_pkg::WORD_W-1:0]   value_low,
  input  logic [act_pkg::WORD_W-1:0]   value_high,
  input  logic [act_pkg::KB_W-1:0]     keyboard,
  input  logic [act_pkg::RELAY_W-1:0]  relay_in,
  // Result item channel.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [act_pkg::STATUS_W-1:0] status,
  output logic                         found,
  output logic [act_pkg::RELAY_W-1:0]  relay_out,
  output logic [act_pkg::TOTAL_W-1:0]  entry_total
);

  import act_pkg::*;

  // The count must hold TABLE_DEPTH itself; the address only the rows.
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENTRY_W = $bits(entry_t);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state;
  logic                legacy;
  logic [CNT_W-1:0]    count;

  // The item under work, captured with its value already normalized.
  logic [FUNC_W-1:0]   cur_func;
  entry_t              cur;

  // Scan pipeline: scan_idx is the next row to read, pend marks that the
  // row read in the previous cycle is on the memory output now.
  logic [CNT_W-1:0]    scan_idx;
  logic                pend;

  // Result held until the output register is free.
  logic [STATUS_W-1:0] res_status;
  logic                res_found;
  logic [RELAY_W-1:0]  res_relay;

  logic [VALUE_W-1:0]  val_in;
  logic [VALUE_W-1:0]  val_norm;
  logic                in_acc;
  logic                full;
  logic                re;
  logic                we;
  logic                hit;
  logic                scan_end;
  logic                key_eq;
  logic                kb_ok;
  logic [ENTRY_W-1:0]  rdata;
  entry_t              rd_entry;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign full      = (count >= CNT_W'(TABLE_DEPTH));

  // A value is a zero-terminated string: once a zero character or the
  // character limit is reached, every later character reads as zero.
  assign val_in = {value_high, value_low};

  always_comb begin
    logic live;
    live     = 1'b1;
    val_norm = '0;
    for (int i = 0; i < VALUE_BYTES; i++) begin
      live = live && (i < VALUE_CHARS) && (val_in[i*8 +: 8] != 8'd0);
      val_norm[i*8 +: 8] = live ? val_in[i*8 +: 8] : 8'd0;
    end
  end

  // Row compare against the memory output. A lookup accepts a row stored
  // for any keyboard, for the asked keyboard, or any row in legacy format;
  // the duplicate check of an add needs the exact keyboard.
  assign rd_entry = entry_t'(rdata);
  assign key_eq   = (rd_entry.type_code == cur.type_code) && (rd_entry.value == cur.value);
  assign kb_ok    = (cur_func == FUNC_LOOKUP) ?
                    (legacy || (rd_entry.keyboard == KB_ANY) ||
                     (rd_entry.keyboard == cur.keyboard)) :
                    (rd_entry.keyboard == cur.keyboard);
  assign hit      = pend && key_eq && kb_ok;

  // Read rows 0 .. count-1 in order and stop at the first hit, so a row
  // that was never written is never read.
  assign re       = (state == S_SCAN) && (scan_idx < count) && !hit;
  assign scan_end = (state == S_SCAN) && (hit || (!pend && (scan_idx >= count)));

  // A successful add appends at the current count; the next item cannot
  // start its scan before this write has landed.
  assign we = scan_end && (cur_func == FUNC_ADD) && !hit;

  act_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_act_ram (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (cur),
    .re    (re),
    .raddr (scan_idx[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      legacy    <= 1'b0;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        legacy <= cfg_data;
      end
      pend <= re;
      if (re) begin
        scan_idx <= scan_idx + 1'b1;
      end
      // In the done state the hand-over below owns out_valid.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            cur_func       <= func;
            cur.type_code  <= type_code;
            cur.value      <= val_norm;
            cur.keyboard   <= keyboard;
            cur.relay      <= relay_in;
            scan_idx       <= '0;
            res_found      <= 1'b0;
            res_relay      <= RELAY_NONE;
            case (func)
              FUNC_LOOKUP: begin
                res_status <= ST_OK;
                state      <= S_SCAN;
              end
              FUNC_ADD: begin
                // Operand checks in priority order; only a clean add scans
                // the table for a duplicate.
                if (full) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else if (keyboard > KB_MAX) begin
                  res_status <= ST_BAD_KEYBOARD;
                  state      <= S_DONE;
                end else if ((relay_in != RELAY_ONE) && (relay_in != RELAY_TWO)) begin
                  res_status <= ST_BAD_RELAY;
                  state      <= S_DONE;
                end else if (val_norm[7:0] == 8'd0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_SCAN;
                end
              end
              FUNC_CLEAR: begin
                res_status <= ST_OK;
                count      <= '0;
                state      <= S_DONE;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            if (cur_func == FUNC_LOOKUP) begin
              res_found <= hit;
              res_relay <= hit ? rd_entry.relay : RELAY_NONE;
            end else if (hit) begin
              res_status <= ST_DUPLICATE;
            end else begin
              count <= count + 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // Hand the result over once the output register is free.
          if (!out_valid || out_ready) begin
            status      <= res_status;
            found       <= res_found;
            relay_out   <= res_relay;
            entry_total <= TOTAL_W'(count);
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/act_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module act_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/act_checker.sv
// Port-level checker of the access code table, bound to the top level.
// Depends on act_pkg and access_code_table_defines.svh.
`include "access_code_table_defines.svh"

module act_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [act_pkg::STATUS_W-1:0] status,
  input logic                         found,
  input logic [act_pkg::RELAY_W-1:0]  relay_out,
  input logic [act_pkg::TOTAL_W-1:0]  entry_total
);

  import act_pkg::*;

  logic                                            in_acc;
  logic                                            res_hit;
  logic                                            out_stall;
  logic [STATUS_W+1+RELAY_W+TOTAL_W-1:0]           res_bus;

  assign in_acc    = in_valid && in_ready;
  assign res_hit   = out_valid && found;
  assign out_stall = out_valid && !out_ready;
  assign res_bus   = {status, found, relay_out, entry_total};

  // A hit is only reported by a lookup, which always ends with status ok
  // and a stored relay, which an add never lets be zero.
  `ACT_ASSERT_NOW(a_found_ok, res_hit, (status == ST_OK) && (relay_out != RELAY_NONE), "bad hit")

  // Without a hit the relay field must be zero.
  `ACT_ASSERT_NOW(a_miss_relay, out_valid && !found, relay_out == RELAY_NONE, "relay set, no hit")

  // Only the defined status codes ever appear.
  `ACT_ASSERT_NOW(a_status_range, out_valid, status <= ST_DUPLICATE, "undefined status code")

  // A stalled result keeps its value.
  `ACT_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(res_bus), "stalled result changed")

  // Only one item is worked on at a time.
  `ACT_ASSERT_NEXT(a_one_item, in_acc, !in_ready, "input taken while busy")

endmodule

bind access_code_table act_checker u_act_checker (.*);

>>> test/access_code_table_tb.sv
// Self-checking testbench for the access code table: lookup, add and clear items
// with random gaps on both channels. It depends on act_pkg and access_code_table.
module access_code_table_tb;
  import act_pkg::*;

  // The item encoding has one func value that the package leaves unnamed.
  // The block must treat it as a no-op.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int CHARS = VALUE_CHARS_DEF;
  localparam int POOL_SIZE = 10;
  localparam int PHASE_ITEMS = 160;
  localparam int SETTLE_CYCLES = 50;
  localparam int CYCLE_LIMIT = 400000;

  // One result item as the block reports it.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [RELAY_W-1:0]  relay;
    logic [TOTAL_W-1:0]  total;
  } table_reply_t;

  // Shadow copy of the credential table. Every accepted request item is run
  // through it, and the reply it predicts waits in a queue until the block's
  // result item arrives.
  class credential_scoreboard;
    bit           legacy;
    int           count;
    entry_t       rows[DEPTH];
    table_reply_t expected_replies[$];
    int           errors;
    int           checked;
    int           lookups_found;
    int           add_status_hits[6];

    function void set_legacy(bit v);
      legacy = v;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // Characters after the first zero character do not belong to the code.
    function logic [VALUE_W-1:0] trim_code(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
      logic [VALUE_W-1:0] v;
      bit                 ended;
      v = {hi, lo};
      ended = 0;
      for (int i = 0; i < VALUE_BYTES; i++) begin
        if (i >= CHARS || v[i*8 +: 8] == 8'd0) ended = 1;
        if (ended) v[i*8 +: 8] = 8'd0;
      end
      return v;
    endfunction

    function void note_request(logic [FUNC_W-1:0] f, logic [TYPE_W-1:0] t,
                               logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi,
                               logic [KB_W-1:0] kb, logic [RELAY_W-1:0] rl);
      logic [VALUE_W-1:0] v;
      table_reply_t       r;
      v = trim_code(lo, hi);
      r = '0;
      case (f)
        FUNC_LOOKUP: begin
          for (int i = 0; i < count; i++) begin
            if (!r.found && rows[i].type_code == t && rows[i].value == v &&
                (legacy || rows[i].keyboard == KB_ANY || rows[i].keyboard == kb)) begin
              r.found = 1'b1;
              r.relay = rows[i].relay;
            end
          end
          if (r.found) lookups_found++;
        end
        FUNC_ADD: begin
          if (count >= DEPTH) r.status = ST_FULL;
          else if (kb > KB_MAX) r.status = ST_BAD_KEYBOARD;
          else if (rl != RELAY_ONE && rl != RELAY_TWO) r.status = ST_BAD_RELAY;
          else if (v[7:0] == 8'd0) r.status = ST_EMPTY;
          else begin
            for (int i = 0; i < count; i++) begin
              if (rows[i].type_code == t && rows[i].value == v && rows[i].keyboard == kb)
                r.status = ST_DUPLICATE;
            end
            if (r.status == ST_OK) begin
              rows[count] = '{type_code: t, value: v, keyboard: kb, relay: rl};
              count++;
            end
          end
          add_status_hits[r.status]++;
        end
        FUNC_CLEAR: count = 0;
        default: ;
      endcase
      r.total = count[TOTAL_W-1:0];
      expected_replies.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(table_reply_t got);
      table_reply_t want;
      checked++;
      if (expected_replies.size() == 0) begin
        $display("%0t: result item with nothing expected, actual status %0d found %0d",
                 $time, got.status, got.found);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("found", want.found, got.found);
      compare_field("relay_out", want.relay, got.relay);
      compare_field("entry_total", want.total, got.total);
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_data = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [FUNC_W-1:0]   func = FUNC_LOOKUP;
  logic [TYPE_W-1:0]   type_code = '0;
  logic [WORD_W-1:0]   value_low = '0;
  logic [WORD_W-1:0]   value_high = '0;
  logic [KB_W-1:0]     keyboard = '0;
  logic [RELAY_W-1:0]  relay_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [RELAY_W-1:0]  relay_out;
  logic [TOTAL_W-1:0]  entry_total;

  credential_scoreboard sb;
  int                   items_sent;
  int                   legacy_writes;
  int                   cycle_count;
  int                   burst_left;
  logic [VALUE_W-1:0]   code_pool[POOL_SIZE];
  int                   code_len[POOL_SIZE];

  access_code_table dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .type_code(type_code),
    .value_low(value_low),
    .value_high(value_high),
    .keyboard(keyboard),
    .relay_in(relay_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .found(found),
    .relay_out(relay_out),
    .entry_total(entry_total)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog. A correct run ends far below this count, even with the longest
  // gaps on both sides and a full-table scan behind every item.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d result items still outstanding", $time, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Handshake monitor. Signals read right after the edge still hold the values
  // that the edge sampled, because both sides update them with nonblocking
  // assignments. The result is checked before the new request item is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_reply('{status: status, found: found, relay: relay_out, total: entry_total});
      if (in_valid && in_ready)
        sb.note_request(func, type_code, value_low, value_high, keyboard, relay_in);
      if (cfg_valid && cfg_ready)
        sb.set_legacy(cfg_data);
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // The receiver alternates ready stretches with stalls. Some ready stretches
  // are long, so there are also runs where no result item is held back.
  initial begin
    int run_len;
    int stall_len;
    wait (rst == 1'b0);
    forever begin
      run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Presents one request item and holds it until the block takes it. Valid is
  // left high, so the caller either follows with the next item or lowers it.
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [TYPE_W-1:0] t,
                              input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                              input logic [KB_W-1:0] kb, input logic [RELAY_W-1:0] rl);
    in_valid   <= 1'b1;
    func       <= f;
    type_code  <= t;
    value_low  <= lo;
    value_high <= hi;
    keyboard   <= kb;
    relay_in   <= rl;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic sender_gap(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Sender pause: nothing new goes in until every result item has come back.
  // Comparing counts avoids a race with the monitor at the same edge.
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (sb.checked != items_sent) @(posedge clk);
  endtask

  // Writes legacy_format. It is only called while the block has no item in flight.
  task automatic write_legacy(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    legacy_writes++;
  endtask

  task automatic directed_request(input logic [FUNC_W-1:0] f, input logic [TYPE_W-1:0] t,
                                  input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                                  input logic [KB_W-1:0] kb, input logic [RELAY_W-1:0] rl);
    send_request(f, t, lo, hi, kb, rl);
    sender_gap(pick_gap());
  endtask

  // Picks a code value. Most come from a small pool, so that duplicates and
  // lookup hits are common. Pool codes shorter than 16 characters sometimes
  // carry junk after the terminating zero, which must not affect matching.
  function automatic logic [VALUE_W-1:0] pick_code();
    logic [VALUE_W-1:0] v;
    int unsigned        r;
    int                 k;
    r = $urandom_range(0, 99);
    if (r < 6) return {$urandom, $urandom, $urandom, $urandom};
    if (r < 10) begin
      v = {$urandom, $urandom, $urandom, $urandom};
      v[7:0] = 8'd0;
      return v;
    end
    k = $urandom_range(0, POOL_SIZE - 1);
    v = code_pool[k];
    if (code_len[k] < VALUE_BYTES && $urandom_range(0, 2) == 0) begin
      for (int b = code_len[k] + 1; b < VALUE_BYTES; b++) v[b*8 +: 8] = 8'($urandom);
    end
    return v;
  endfunction

  // Random request item. Adds and lookups dominate; a clear is rare so the
  // table regularly fills up to its full depth.
  task automatic random_request();
    logic [FUNC_W-1:0]  f;
    logic [TYPE_W-1:0]  t;
    logic [VALUE_W-1:0] v;
    logic [KB_W-1:0]    kb;
    logic [RELAY_W-1:0] rl;
    int unsigned        r;
    r = $urandom_range(0, 99);
    if (r < 50) f = FUNC_ADD;
    else if (r < 95) f = FUNC_LOOKUP;
    else if (r < 96) f = FUNC_CLEAR;
    else f = FUNC_UNUSED;
    t  = ($urandom_range(0, 9) == 0) ? TYPE_W'($urandom_range(0, 255)) :
                                       TYPE_W'($urandom_range(0, 3));
    v  = pick_code();
    kb = ($urandom_range(0, 9) == 0) ? 2'd3 : KB_W'($urandom_range(0, 2));
    if ($urandom_range(0, 99) < 85) rl = RELAY_W'($urandom_range(1, 2));
    else rl = ($urandom_range(0, 1) == 1) ? 2'd3 : RELAY_NONE;
    send_request(f, t, v[WORD_W-1:0], v[VALUE_W-1:WORD_W], kb, rl);
  endtask

  initial begin
    sb = new();
    for (int k = 0; k < POOL_SIZE; k++) begin
      code_len[k] = (k == 0) ? VALUE_BYTES : (k == 1) ? 1 : $urandom_range(1, VALUE_BYTES);
      code_pool[k] = '0;
      for (int b = 0; b < code_len[k]; b++) code_pool[k][b*8 +: 8] = 8'($urandom_range(1, 255));
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_legacy(1'b0);

    // Directed part, strict keyboard matching first.
    // Lookup on an empty table, with every input bit high.
    directed_request(FUNC_LOOKUP, 8'hFF, '1, '1, 2'd3, 2'd3);
    // Each add rejection on its own, in priority order below a full table.
    directed_request(FUNC_ADD, 8'h12, 64'h41, 64'h0, 2'd3, RELAY_ONE);
    directed_request(FUNC_ADD, 8'h12, 64'h41, 64'h0, 2'd1, RELAY_NONE);
    directed_request(FUNC_ADD, 8'h12, 64'h41, 64'h0, 2'd1, 2'd3);
    directed_request(FUNC_ADD, 8'h12, 64'hFFFF_FFFF_FFFF_FF00, '1, 2'd1, RELAY_ONE);
    // A full 16-character code on keyboard 2, then the same one again.
    directed_request(FUNC_ADD, 8'hFF, '1, '1, KB_MAX, RELAY_TWO);
    directed_request(FUNC_ADD, 8'hFF, '1, '1, KB_MAX, RELAY_TWO);
    // Same code on another keyboard is a new entry.
    directed_request(FUNC_ADD, 8'hFF, '1, '1, 2'd1, RELAY_ONE);
    // A one-character code with junk after its terminator, for any keyboard.
    directed_request(FUNC_ADD, 8'h00, 64'hDEAD_BEEF_CA00_0041, '1, KB_ANY, RELAY_ONE);
    // The clean form of that code is a duplicate.
    directed_request(FUNC_ADD, 8'h00, 64'h41, 64'h0, KB_ANY, RELAY_TWO);
    // An any-keyboard entry matches keyboard 3 as well.
    directed_request(FUNC_LOOKUP, 8'h00, 64'h41, 64'h0, 2'd3, RELAY_NONE);
    directed_request(FUNC_LOOKUP, 8'hFF, '1, '1, KB_ANY, RELAY_NONE);
    directed_request(FUNC_LOOKUP, 8'hFF, '1, '1, 2'd1, RELAY_NONE);
    directed_request(FUNC_LOOKUP, 8'hFF, '1, '1, KB_MAX, RELAY_NONE);
    // Same value with a different type must miss, and so must an empty value.
    directed_request(FUNC_LOOKUP, 8'h01, 64'h41, 64'h0, KB_ANY, RELAY_NONE);
    directed_request(FUNC_LOOKUP, 8'h00, 64'h0, 64'h0, KB_ANY, RELAY_NONE);
    directed_request(FUNC_UNUSED, 8'hFF, '1, '1, 2'd3, 2'd3);
    wait_for_replies();

    // Old table format: the stored keyboard no longer restricts a lookup.
    write_legacy(1'b1);
    directed_request(FUNC_LOOKUP, 8'hFF, '1, '1, KB_ANY, RELAY_NONE);
    directed_request(FUNC_LOOKUP, 8'hFF, '1, '1, 2'd3, RELAY_NONE);
    directed_request(FUNC_CLEAR, 8'h00, 64'h0, 64'h0, KB_ANY, RELAY_NONE);
    directed_request(FUNC_LOOKUP, 8'hFF, '1, '1, 2'd1, RELAY_NONE);
    directed_request(FUNC_UNUSED, 8'h00, 64'h0, 64'h0, KB_ANY, RELAY_NONE);
    wait_for_replies();

    // Random phases, alternating the format setting between them.
    for (int phase = 0; phase < 4; phase++) begin
      write_legacy(phase[0] ? 1'b1 : 1'b0);
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_request();
        if (burst_left == 0 && $urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 40);
        if ($urandom_range(0, 59) == 0) wait_for_replies();
        else if (burst_left > 0) burst_left--;
        else sender_gap(pick_gap());
      end
      wait_for_replies();
    end

    // Nothing more goes in; give the block time to show any stray result.
    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d request items over %0d format writes, %0d lookups matched.",
             items_sent, legacy_writes, sb.lookups_found);
    $display("Add outcomes: ok %0d, full %0d, bad keyboard %0d, bad relay %0d, empty %0d, dup %0d.",
             sb.add_status_hits[ST_OK], sb.add_status_hits[ST_FULL],
             sb.add_status_hits[ST_BAD_KEYBOARD], sb.add_status_hits[ST_BAD_RELAY],
             sb.add_status_hits[ST_EMPTY], sb.add_status_hits[ST_DUPLICATE]);
    if (sb.pending() != 0)
      $display("%0t: %0d expected result items never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/act_pkg.sv
rtl/core/act_ram.sv
rtl/core/access_code_table.sv
rtl/core/act_checker.sv
test/access_code_table_tb.sv
